[hdl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Types and character constants shared by the percent decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] HIGH_BIT_MASK = 8'h80;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       is_last;
      logic       malformed;
   } rsp_type;

   // input register contents handed to the decoder
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

   // zero to two results produced by one request
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } pair_type;

endpackage

[hdl/upd_req_if.sv]
// ----------------------------------------------------------------------------
// upd_req_if
// Request channel: one raw byte of the encoded string and its end mark.
// ----------------------------------------------------------------------------
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[hdl/upd_rsp_if.sv]
// ----------------------------------------------------------------------------
// upd_rsp_if
// Result channel: one decoded byte, separator or bare end marker.
// ----------------------------------------------------------------------------
interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       is_last;
   logic       malformed;

   modport source (output valid, output out_byte, output byte_valid,
                   output is_last, output malformed, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input is_last, input malformed, output ready);
endinterface

[hdl/upd_in_stage.sv]
// ----------------------------------------------------------------------------
// upd_in_stage
// Input register: holds one request until the result buffer can take it.
// ----------------------------------------------------------------------------
module upd_in_stage
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_item,
   input  logic      advance,
   output stage_type stage
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[hdl/upd_decode.sv]
// ----------------------------------------------------------------------------
// upd_decode
// Decode state machine: maps one request to zero, one or two results.
// ----------------------------------------------------------------------------
module upd_decode
   import upd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  item,
   input  logic     append_sep,
   output pair_type pair
);

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_PAIR   = 2'd1,
      PH_HEX1   = 2'd2,
      PH_HEX2   = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] nibble_ff, nibble_in;
   logic       digit_err_ff, digit_err_in;

   logic       hex_ok;
   logic [3:0] hex_val;
   logic       have0;
   logic       cut;
   rsp_type    r0;
   rsp_type    sep;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39) begin
         hex_val = item.in_byte[3:0];
      end else if ((item.in_byte >= 8'h41 && item.in_byte <= 8'h46) ||
                   (item.in_byte >= 8'h61 && item.in_byte <= 8'h66)) begin
         // letters A-F / a-f: low three bits are 1..6
         hex_val = 4'd9 + {1'b0, item.in_byte[2:0]};
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      nibble_in    = nibble_ff;
      digit_err_in = digit_err_ff;
      have0        = 1'b0;
      r0           = '{out_byte: item.in_byte, byte_valid: 1'b1,
                       is_last: 1'b0, malformed: 1'b0};
      case (phase_ff)
         PH_NORMAL: begin
            if ((item.in_byte & HIGH_BIT_MASK) != 8'h00) begin
               have0    = 1'b1;
               phase_in = PH_PAIR;
            end else if (item.in_byte == CHAR_PLUS) begin
               have0       = 1'b1;
               r0.out_byte = CHAR_SPACE;
            end else if (item.in_byte == CHAR_PERCENT) begin
               phase_in = PH_HEX1;
            end else begin
               have0 = 1'b1;
            end
         end
         PH_PAIR: begin
            have0    = 1'b1;
            phase_in = PH_NORMAL;
         end
         PH_HEX1: begin
            nibble_in    = hex_val;
            digit_err_in = !hex_ok;
            phase_in     = PH_HEX2;
         end
         PH_HEX2: begin
            have0 = 1'b1;
            if (hex_ok && !digit_err_ff) begin
               r0.out_byte = {nibble_ff, hex_val};
            end else begin
               r0.out_byte  = 8'h00;
               r0.malformed = 1'b1;
            end
            phase_in     = PH_NORMAL;
            nibble_in    = 4'd0;
            digit_err_in = 1'b0;
         end
         default: begin
            phase_in = PH_NORMAL;
         end
      endcase

      cut = (phase_in != PH_NORMAL);
      sep = '{out_byte: CHAR_SEMI, byte_valid: 1'b1, is_last: 1'b1, malformed: cut};

      pair.count  = have0 ? 2'd1 : 2'd0;
      pair.first  = r0;
      pair.second = sep;
      if (item.in_last) begin
         if (append_sep) begin
            if (have0) begin
               pair.count = 2'd2;
            end else begin
               pair.count = 2'd1;
               pair.first = sep;
            end
         end else if (have0) begin
            pair.first.is_last   = 1'b1;
            pair.first.malformed = r0.malformed | cut;
         end else begin
            // bare end marker
            pair.count = 2'd1;
            pair.first = '{out_byte: 8'h00, byte_valid: 1'b0, is_last: 1'b1,
                           malformed: cut};
         end
         phase_in     = PH_NORMAL;
         nibble_in    = 4'd0;
         digit_err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NORMAL;
         nibble_ff    <= 4'd0;
         digit_err_ff <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         nibble_ff    <= nibble_in;
         digit_err_ff <= digit_err_in;
      end
   end

endmodule

[hdl/upd_out_stage.sv]
// ----------------------------------------------------------------------------
// upd_out_stage
// Result register: holds the results of one request and sends them in order.
// ----------------------------------------------------------------------------
module upd_out_stage
   import upd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load_valid,
   input  pair_type pair,
   output logic     free,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_item
);

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       pop;
   logic       load;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = head_ff;
   assign pop       = rsp_valid && rsp_ready;
   // buffer is empty now or drains its last result this cycle
   assign free      = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);
   assign load      = load_valid && free;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (load) begin
         count_in = pair.count;
         head_in  = pair.first;
         tail_in  = pair.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

[hdl/url_percent_decoder_unit.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Path: a request passes the input register and then the result register
// before its first result is on the result port.
// Throughput: one request per cycle while the single result register is free;
// two results (data byte plus separator) hold it until both are sent.
// Reset: synchronous; clears decode phase, buffers and append_separator.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit
   import upd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_chan,
   upd_rsp_if.source rsp_chan,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   logic      append_ff;
   stage_type stage;
   pair_type  pair;
   req_type   req_item;
   rsp_type   rsp_item;
   logic      free;
   logic      fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         append_ff <= 1'b0;
      end else if (csr_we) begin
         append_ff <= csr_wdata;
      end
   end

   assign req_item.in_byte = req_chan.in_byte;
   assign req_item.in_last = req_chan.in_last;
   assign fire             = stage.valid && free;

   upd_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_item  (req_item),
      .advance   (fire),
      .stage     (stage)
   );

   upd_decode u_dec (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (stage.item),
      .append_sep (append_ff),
      .pair       (pair)
   );

   upd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (stage.valid),
      .pair       (pair),
      .free       (free),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_chan.out_byte   = rsp_item.out_byte;
   assign rsp_chan.byte_valid = rsp_item.byte_valid;
   assign rsp_chan.is_last    = rsp_item.is_last;
   assign rsp_chan.malformed  = rsp_item.malformed;

endmodule
